// ----- src/rpc_pkg.sv -----
// rpc_pkg: shared types and constants for the restricted partition counter
// no dependencies; used by the interfaces, the sequencer, the row memory and the top level
`default_nettype none

package rpc_pkg;

    // fixed field widths
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned ROW_ADDR_W = 7;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_ADD,
        ST_FETCH,
        ST_OUT
    } t_rpc_state;

    // row memory access from the sequencer
    typedef struct packed {
        logic                  we;
        logic [ROW_ADDR_W-1:0] waddr;
        logic [COUNT_W-1:0]    wdata;
        logic [ROW_ADDR_W-1:0] raddr_a;
        logic [ROW_ADDR_W-1:0] raddr_b;
    } t_mem_req;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_rpc_status;

endpackage

`default_nettype wire

// ----- src/rpc_if.sv -----
// rpc_query_if and rpc_result_if: valid/ready channels of the partition counter
// depends on rpc_pkg for field widths
`default_nettype none

interface rpc_query_if;
    logic                         valid;
    logic                         ready;
    logic [rpc_pkg::TOTAL_W-1:0]  total;
    logic [rpc_pkg::TOTAL_W-1:0]  largest_part;

    modport source (output valid, output total, output largest_part, input ready);
    modport sink   (input valid, input total, input largest_part, output ready);
endinterface

interface rpc_result_if;
    logic                         valid;
    logic                         ready;
    logic [rpc_pkg::COUNT_W-1:0]  way_count;

    modport source (output valid, output way_count, input ready);
    modport sink   (input valid, input way_count, output ready);
endinterface

`default_nettype wire

// ----- src/restricted_partition_counter_core.sv -----
// restricted_partition_counter_core: top level of the partition counter
// depends on rpc_pkg, rpc_if, rpc_row_mem and rpc_ctrl
//
//   channel    dir   handshake       payload
//   i_query    in    valid / ready   total[6:0], largest_part[6:0]
//   o_result   out   valid / ready   way_count[31:0]
//
// one query at a time: the sequencer clears row entries 0..T (T = clamped total),
// then for each part size p = 1..L (L = clamped largest part) adds entry j-p
// into entry j for j = p..T through a read step and an add step on the single
// adder, then reads the answer at entry T and hands it over.
// reset is synchronous, active low; it idles the sequencer and empties the
// output register. a full output register stalls only the final handover.
`default_nettype none

module restricted_partition_counter_core #(
    parameter int unsigned MAX_TOTAL = 127
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    rpc_query_if.sink           i_query,
    rpc_result_if.source        o_result
);

    localparam int unsigned ADDR_W = (MAX_TOTAL < 2) ? 1 : $clog2(MAX_TOTAL + 1);

    rpc_pkg::t_mem_req           w_mem;
    rpc_pkg::t_rpc_status        w_status;
    logic [rpc_pkg::COUNT_W-1:0] w_rd_a;
    logic [rpc_pkg::COUNT_W-1:0] w_rd_b;
    logic                        w_start;
    logic                        w_out_free;

    logic                        r_out_valid;
    logic [rpc_pkg::COUNT_W-1:0] r_way_count;

    // query transaction
    assign i_query.ready = w_status.idle;
    assign w_start       = i_query.valid & w_status.idle;

    // output slot is free when empty or being taken
    assign w_out_free = ~r_out_valid | o_result.ready;

    rpc_ctrl #(
        .MAX_TOTAL (MAX_TOTAL),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_total        (i_query.total),
        .i_largest_part (i_query.largest_part),
        .i_out_free     (w_out_free),
        .i_rd_a         (w_rd_a),
        .i_rd_b         (w_rd_b),
        .o_mem          (w_mem),
        .o_status       (w_status)
    );

    rpc_row_mem #(
        .ADDR_W (ADDR_W)
    ) u_row_mem (
        .i_clk  (i_clk),
        .i_req  (w_mem),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_way_count <= w_rd_a;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.way_count = r_way_count;

endmodule

`default_nettype wire

// ----- src/rpc_row_mem.sv -----
// rpc_row_mem: count row store, one write port and two registered read ports
// depends on rpc_pkg for the access struct
`default_nettype none

module rpc_row_mem #(
    parameter int unsigned ADDR_W = 7
) (
    input  wire logic                        i_clk,
    input  wire rpc_pkg::t_mem_req           i_req,
    output logic [rpc_pkg::COUNT_W-1:0]      o_rd_a,
    output logic [rpc_pkg::COUNT_W-1:0]      o_rd_b
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [rpc_pkg::COUNT_W-1:0] r_row [DEPTH];
    logic [rpc_pkg::COUNT_W-1:0] r_rd_a;
    logic [rpc_pkg::COUNT_W-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_row[i_req.waddr[ADDR_W-1:0]] <= i_req.wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_row[i_req.raddr_a[ADDR_W-1:0]];
        r_rd_b <= r_row[i_req.raddr_b[ADDR_W-1:0]];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

// ----- src/rpc_ctrl.sv -----
// rpc_ctrl: sequencer and shared 32-bit adder that fill the count row
// depends on rpc_pkg; drives rpc_row_mem
`default_nettype none

module rpc_ctrl #(
    parameter int unsigned MAX_TOTAL = 127,
    parameter int unsigned ADDR_W    = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rpc_pkg::TOTAL_W-1:0]   i_total,
    input  wire logic [rpc_pkg::TOTAL_W-1:0]   i_largest_part,
    input  wire logic                          i_out_free,
    input  wire logic [rpc_pkg::COUNT_W-1:0]   i_rd_a,
    input  wire logic [rpc_pkg::COUNT_W-1:0]   i_rd_b,
    output rpc_pkg::t_mem_req                  o_mem,
    output rpc_pkg::t_rpc_status               o_status
);

    localparam logic [rpc_pkg::TOTAL_W-1:0] TOTAL_CAP = rpc_pkg::TOTAL_W'(MAX_TOTAL);

    rpc_pkg::t_rpc_state r_state, n_state;
    logic [ADDR_W-1:0] r_total, n_total;
    logic [ADDR_W-1:0] r_largest, n_largest;
    logic [ADDR_W-1:0] r_part, n_part;
    logic [ADDR_W-1:0] r_idx, n_idx;

    logic [rpc_pkg::TOTAL_W-1:0] w_total_sat;
    logic [rpc_pkg::TOTAL_W-1:0] w_largest_sat;
    logic [rpc_pkg::COUNT_W-1:0] w_sum;

    // clamp the query to the row depth and the part size to the total
    always_comb begin
        w_total_sat   = (i_total > TOTAL_CAP) ? TOTAL_CAP : i_total;
        w_largest_sat = (i_largest_part > w_total_sat) ? w_total_sat : i_largest_part;
    end

    // shared adder
    assign w_sum = i_rd_a + i_rd_b;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rpc_pkg::ST_IDLE;
            r_total   <= '0;
            r_largest <= '0;
            r_part    <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_largest <= n_largest;
            r_part    <= n_part;
            r_idx     <= n_idx;
        end
    end

    // next state and memory access
    always_comb begin
        n_state         = r_state;
        n_total         = r_total;
        n_largest       = r_largest;
        n_part          = r_part;
        n_idx           = r_idx;
        o_mem.we        = 1'b0;
        o_mem.waddr     = rpc_pkg::ROW_ADDR_W'(r_idx);
        o_mem.wdata     = '0;
        o_mem.raddr_a   = rpc_pkg::ROW_ADDR_W'(r_idx);
        o_mem.raddr_b   = rpc_pkg::ROW_ADDR_W'(ADDR_W'(r_idx - r_part));
        o_status.idle   = 1'b0;
        o_status.done   = 1'b0;
        unique case (r_state)
            rpc_pkg::ST_IDLE: begin
                o_status.idle = 1'b1;
                if (i_start) begin
                    n_total   = ADDR_W'(w_total_sat);
                    n_largest = ADDR_W'(w_largest_sat);
                    n_idx     = '0;
                    n_state   = rpc_pkg::ST_CLEAR;
                end
            end
            // clear entries 0..total, entry 0 holds the empty sum
            rpc_pkg::ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = (r_idx == '0) ? rpc_pkg::COUNT_W'(1) : '0;
                if (r_idx == r_total) begin
                    if (r_largest == '0) begin
                        n_state = rpc_pkg::ST_FETCH;
                    end else begin
                        n_part  = ADDR_W'(1);
                        n_idx   = ADDR_W'(1);
                        n_state = rpc_pkg::ST_RD;
                    end
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            // read entries j and j - part
            rpc_pkg::ST_RD: begin
                n_state = rpc_pkg::ST_ADD;
            end
            // write back the sum and step j, then the part size
            rpc_pkg::ST_ADD: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = w_sum;
                if (r_idx == r_total) begin
                    if (r_part == r_largest) begin
                        n_state = rpc_pkg::ST_FETCH;
                    end else begin
                        n_part  = r_part + ADDR_W'(1);
                        n_idx   = r_part + ADDR_W'(1);
                        n_state = rpc_pkg::ST_RD;
                    end
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = rpc_pkg::ST_RD;
                end
            end
            // read the answer at index total
            rpc_pkg::ST_FETCH: begin
                o_mem.raddr_a = rpc_pkg::ROW_ADDR_W'(r_total);
                n_state       = rpc_pkg::ST_OUT;
            end
            // hand the answer over once the output register is free
            rpc_pkg::ST_OUT: begin
                o_mem.raddr_a = rpc_pkg::ROW_ADDR_W'(r_total);
                if (i_out_free) begin
                    o_status.done = 1'b1;
                    n_state       = rpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpc_pkg::ST_IDLE;
            end
        endcase
    end

    // checks on the sequencer
    a_add_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpc_pkg::ST_ADD) |-> (r_part != '0) && (r_idx >= r_part))
        else $error("add step with index below part size");

    a_rd_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpc_pkg::ST_RD) |=> (r_state == rpc_pkg::ST_ADD))
        else $error("read step not followed by add step");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (o_mem.waddr <= rpc_pkg::ROW_ADDR_W'(r_total)))
        else $error("row write beyond the query total");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |=> (r_state == rpc_pkg::ST_IDLE))
        else $error("sequencer not idle after result");

    a_part_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpc_pkg::ST_RD) |-> (r_part <= r_largest) && (r_largest <= r_total))
        else $error("part size outside its bound");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for restricted_partition_counter_core, queries in, way counts out
// depends on rpc_pkg, rpc_if and the core; predicts each count with its own table fill

module tb_top;

    localparam int unsigned MAX_TOTAL   = 127;
    localparam int unsigned IDLE_PCT    = 11;
    localparam int unsigned NUM_RANDOM  = 80;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int unsigned SETTLE_CYC  = 40;

    // one pending query and how it is to be sent
    typedef struct {
        logic [rpc_pkg::TOTAL_W-1:0] total;
        logic [rpc_pkg::TOTAL_W-1:0] largest_part;
        bit                          drain_first;
        bit                          calm;
    } t_query;

    logic i_clk;
    logic i_rst_n;

    rpc_query_if  query_ch ();
    rpc_result_if result_ch ();

    restricted_partition_counter_core #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch)
    );

    t_query                        pending_queries[$];
    logic [rpc_pkg::COUNT_W-1:0]   expected_counts[$];
    int unsigned                   num_queries;
    int unsigned                   queries_accepted;
    int unsigned                   counts_seen;
    int unsigned                   error_count;
    int unsigned                   cycle_count;
    bit                            query_taken;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // partitions of total into parts no larger than largest, built row by row
    function automatic logic [rpc_pkg::COUNT_W-1:0] count_partitions(
        logic [rpc_pkg::TOTAL_W-1:0] total,
        logic [rpc_pkg::TOTAL_W-1:0] largest);
        logic [rpc_pkg::COUNT_W-1:0] ways [0:MAX_TOTAL];
        int unsigned                 t;
        int unsigned                 l;
        t = total;
        if (t > MAX_TOTAL) t = MAX_TOTAL;
        l = largest;
        if (l > t) l = t;
        for (int unsigned i = 0; i <= MAX_TOTAL; i++) ways[i] = '0;
        ways[0] = rpc_pkg::COUNT_W'(1);
        for (int unsigned p = 1; p <= l; p++) begin
            for (int unsigned j = p; j <= t; j++) begin
                ways[j] = ways[j] + ways[j - p];
            end
        end
        return ways[t];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_query(input int unsigned total, input int unsigned largest,
                             input bit drain_first, input bit calm);
        t_query q;
        q.total        = total[rpc_pkg::TOTAL_W-1:0];
        q.largest_part = largest[rpc_pkg::TOTAL_W-1:0];
        q.drain_first  = drain_first;
        q.calm         = calm;
        pending_queries.push_back(q);
        num_queries++;
    endtask

    // driver: query side and result ready, both change on the falling edge
    always @(negedge i_clk) begin
        t_query next_q;
        if (i_rst_n) begin
            if (!query_ch.valid || query_taken) begin
                query_taken = 1'b0;
                if (pending_queries.size() == 0) begin
                    query_ch.valid <= 1'b0;
                end else if (pending_queries[0].drain_first &&
                             expected_counts.size() != 0) begin
                    // hold off until every outstanding count is back
                    query_ch.valid <= 1'b0;
                end else if (!pending_queries[0].calm && $urandom_range(99) < IDLE_PCT) begin
                    query_ch.valid <= 1'b0;
                end else begin
                    next_q = pending_queries.pop_front();
                    query_ch.valid        <= 1'b1;
                    query_ch.total        <= next_q.total;
                    query_ch.largest_part <= next_q.largest_part;
                end
            end
            // long calm stretch on the result side
            if (counts_seen >= 40 && counts_seen < 65)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: transactions on both channels, sampled on the rising edge
    always @(posedge i_clk) begin
        logic [rpc_pkg::COUNT_W-1:0] want;
        if (i_rst_n) begin
            if (query_ch.valid && query_ch.ready) begin
                expected_counts.push_back(count_partitions(query_ch.total,
                                                           query_ch.largest_part));
                queries_accepted++;
                query_taken = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                counts_seen++;
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("way_count %0d with no query outstanding",
                                              result_ch.way_count));
                end else begin
                    want = expected_counts.pop_front();
                    if (result_ch.way_count !== want)
                        report_mismatch($sformatf("way_count got %0d want %0d",
                                                  result_ch.way_count, want));
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned t;
        int unsigned l;
        bit          calm;
        num_queries      = 0;
        queries_accepted = 0;
        counts_seen      = 0;
        error_count      = 0;
        cycle_count      = 0;
        query_taken      = 1'b0;
        i_rst_n               = 1'b0;
        query_ch.valid        = 1'b0;
        query_ch.total        = '0;
        query_ch.largest_part = '0;
        result_ch.ready       = 1'b0;

        // directed: zero total, zero largest part, largest above total, extremes
        add_query(0, 0, 0, 0);
        add_query(0, 127, 0, 0);
        add_query(1, 0, 0, 0);
        add_query(127, 0, 0, 0);
        add_query(5, 0, 0, 0);
        add_query(1, 1, 0, 0);
        add_query(1, 127, 0, 0);
        add_query(5, 3, 0, 0);
        add_query(10, 20, 0, 0);
        add_query(20, 20, 0, 0);
        add_query(127, 127, 1, 0);
        add_query(127, 1, 0, 0);
        add_query(127, 126, 0, 0);
        add_query(64, 64, 0, 0);
        add_query(100, 10, 0, 0);
        add_query(85, 42, 0, 0);
        add_query(42, 85, 0, 0);
        add_query(7, 7, 0, 0);
        add_query(3, 2, 0, 0);
        add_query(2, 2, 0, 0);

        // random: mostly small totals, a few up to the top of the range
        for (int unsigned k = 0; k < NUM_RANDOM; k++) begin
            if ($urandom_range(99) < 10)
                t = $urandom_range(127);
            else
                t = $urandom_range(40);
            if ($urandom_range(99) < 20)
                l = $urandom_range(127);
            else
                l = $urandom_range(t);
            calm = (k >= 30 && k < 55);
            add_query(t, l, (k == 70), calm);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for every query to be taken and every count to come back
        do @(negedge i_clk);
        while (!(queries_accepted == num_queries && expected_counts.size() == 0));
        repeat (SETTLE_CYC) @(negedge i_clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rpc_pkg.sv
src/rpc_if.sv
src/rpc_row_mem.sv
src/rpc_ctrl.sv
src/restricted_partition_counter_core.sv
tb/sv/tb_top.sv
